// ===== sv/kvt_pkg.sv =====
// Package for the key/value table: widths, request and status codes,
// sequencer states and the scan summary struct. No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int KVT_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int RANGE_W     = 33;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_GET   = 2'd1,
        KIND_DEL   = 2'd2,
        KIND_RANGE = 2'd3
    } kvt_kind_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_RANGE     = 3'd6
    } kvt_status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } kvt_state_t;

    // Summary gathered over one pass through the store.
    typedef struct packed {
        logic                     hit;
        logic signed [VALUE_W-1:0] hit_value;
        logic                     free;
        logic                     any;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
    } kvt_scan_t;

endpackage

// ===== sv/kvt_store.sv =====
// Entry store of the key/value table: one write port, one registered read port.
// Each word holds a valid mark, a key and a value. Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_store
    import kvt_pkg::*;
#(
    parameter int ENTRIES = KVT_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic                      wr_valid,
    input  logic signed [KEY_W-1:0]   wr_key,
    input  logic signed [VALUE_W-1:0] wr_value,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic                      rd_valid,
    output logic signed [KEY_W-1:0]   rd_key,
    output logic signed [VALUE_W-1:0] rd_value
);

    localparam int WORD_W = 1 + KEY_W + VALUE_W;

    logic [WORD_W-1:0] mem [ENTRIES];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_valid, wr_key, wr_value};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_valid = rd_word_reg[WORD_W-1];
    assign rd_key   = rd_word_reg[KEY_W+VALUE_W-1:VALUE_W];
    assign rd_value = rd_word_reg[VALUE_W-1:0];

endmodule

// ===== sv/kvt_scan.sv =====
// Shared scan unit: while step is high, looks at one entry per cycle and accumulates the
// key match, the lowest free slot and the value minimum and maximum. Depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_scan
    import kvt_pkg::*;
#(
    parameter int ENTRIES = KVT_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      step,
    input  kvt_kind_t                 kind,
    input  logic signed [KEY_W-1:0]   key,
    input  logic [IDX_W-1:0]          ent_idx,
    input  logic                      ent_valid,
    input  logic signed [KEY_W-1:0]   ent_key,
    input  logic signed [VALUE_W-1:0] ent_value,
    output kvt_scan_t                 summary,
    output logic [IDX_W-1:0]          hit_idx,
    output logic [IDX_W-1:0]          free_idx
);

    kvt_scan_t        sum_reg, sum_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    always_comb
    begin
        sum_next      = sum_reg;
        hit_idx_next  = hit_idx_reg;
        free_idx_next = free_idx_reg;
        if (start)
        begin
            sum_next = '0;
        end
        else if (step)
        begin
            if (kind == KIND_RANGE)
            begin
                if (ent_valid)
                begin
                    if (!sum_reg.any)
                    begin
                        sum_next.any = 1'b1;
                        sum_next.lo  = ent_value;
                        sum_next.hi  = ent_value;
                    end
                    else
                    begin
                        if (ent_value < sum_reg.lo)
                        begin
                            sum_next.lo = ent_value;
                        end
                        if (ent_value > sum_reg.hi)
                        begin
                            sum_next.hi = ent_value;
                        end
                    end
                end
            end
            else
            begin
                if (ent_valid && (ent_key == key) && !sum_reg.hit)
                begin
                    sum_next.hit       = 1'b1;
                    sum_next.hit_value = ent_value;
                    hit_idx_next       = ent_idx;
                end
                if (!ent_valid && !sum_reg.free)
                begin
                    sum_next.free = 1'b1;
                    free_idx_next = ent_idx;
                end
            end
        end
    end

    assign summary  = sum_reg;
    assign hit_idx  = hit_idx_reg;
    assign free_idx = free_idx_reg;

endmodule

// ===== sv/key_value_table_core.sv =====
// Top level of the key/value table: sequencer, request and result registers.
// Instantiates kvt_store and kvt_scan; depends on kvt_pkg.
`timescale 1ns / 1ps

//  Channel   Handshake            Payload
//  input     in_valid, in_stall   kind, key, new_value
//  output    out_valid, out_stall status, found, old_value, value_range, entry_count
//
// Each request passes through S_IDLE, which accepts it, S_SCAN, which streams every
// stored entry through the shared scan unit from the single registered read port,
// and S_FINISH, which updates the store and loads the result. After reset a clearing
// pass marks every entry empty; no item is accepted until it ends. A new item is
// accepted while a result still waits in the output register; only the S_FINISH
// step of that item waits on out_stall.

module key_value_table_core
    import kvt_pkg::*;
#(
    parameter int ENTRIES = KVT_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int CNT_W   = $clog2(ENTRIES + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                kind,
    input  logic signed [KEY_W-1:0]   key,
    input  logic signed [VALUE_W-1:0] new_value,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                status,
    output logic                      found,
    output logic signed [VALUE_W-1:0] old_value,
    output logic signed [RANGE_W-1:0] value_range,
    output logic [CNT_W-1:0]          entry_count
);

    kvt_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    // Latched request.
    kvt_kind_t                 kind_reg;
    logic signed [KEY_W-1:0]   key_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic                      req_load;

    // Result register.
    logic                      out_valid_reg, out_valid_next;
    kvt_status_t               status_reg, status_next;
    logic                      found_reg, found_next;
    logic signed [VALUE_W-1:0] old_reg, old_next;
    logic signed [RANGE_W-1:0] range_reg, range_next;
    logic                      out_load;

    // Store ports.
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic                      wr_valid;
    logic signed [KEY_W-1:0]   wr_key;
    logic signed [VALUE_W-1:0] wr_value;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      ent_valid;
    logic signed [KEY_W-1:0]   ent_key;
    logic signed [VALUE_W-1:0] ent_value;

    // Scan unit.
    logic                      scan_start;
    kvt_scan_t                 summary;
    logic [IDX_W-1:0]          hit_idx;
    logic [IDX_W-1:0]          free_idx;
    logic signed [RANGE_W-1:0] spread;

    kvt_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_valid (wr_valid),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_valid (ent_valid),
        .rd_key   (ent_key),
        .rd_value (ent_value)
    );

    kvt_scan #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .step      (rd_pend_reg),
        .kind      (kind_reg),
        .key       (key_reg),
        .ent_idx   (rd_idx_reg),
        .ent_valid (ent_valid),
        .ent_key   (ent_key),
        .ent_value (ent_value),
        .summary   (summary),
        .hit_idx   (hit_idx),
        .free_idx  (free_idx)
    );

    // The spread of two 32-bit signed values always fits a 33-bit signed field.
    assign spread = {summary.hi[VALUE_W-1], summary.hi} - {summary.lo[VALUE_W-1], summary.lo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            rd_pend_reg   <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_addr;
        if (req_load)
        begin
            kind_reg <= kvt_kind_t'(kind);
            key_reg  <= key;
            val_reg  <= new_value;
        end
        if (out_load)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            old_reg    <= old_next;
            range_reg  <= range_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        req_load       = 1'b0;
        out_load       = 1'b0;
        scan_start     = 1'b0;
        in_stall       = 1'b1;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg[IDX_W-1:0];
        wr_valid       = 1'b0;
        wr_key         = key_reg;
        wr_value       = val_reg;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[IDX_W-1:0];
        status_next    = ST_NOT_FOUND;
        found_next     = 1'b0;
        old_next       = '0;
        range_next     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Mark one entry empty per cycle after reset.
                wr_en    = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    req_load   = 1'b1;
                    scan_start = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Reads are issued for every entry; the scan unit sees each
                // one in the following cycle, so the pass ends in the cycle after the last read.
                if (cnt_reg == CNT_W'(ENTRIES))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (kind_reg == KIND_RANGE)
                    begin
                        status_next = ST_RANGE;
                        range_next  = summary.any ? spread : '1;
                    end
                    else if (summary.hit)
                    begin
                        found_next = 1'b1;
                        old_next   = summary.hit_value;
                        wr_addr    = hit_idx;
                        unique case (kind_reg)
                            KIND_PUT:
                            begin
                                wr_en       = 1'b1;
                                wr_valid    = 1'b1;
                                status_next = ST_UPDATED;
                            end
                            KIND_GET:
                            begin
                                status_next = ST_FOUND;
                            end
                            KIND_DEL:
                            begin
                                wr_en       = 1'b1;
                                count_next  = count_reg - CNT_W'(1);
                                status_next = ST_REMOVED;
                            end
                            default:
                            begin
                                status_next = ST_RANGE;
                            end
                        endcase
                    end
                    else if (kind_reg == KIND_PUT)
                    begin
                        // New key goes into the lowest empty slot, if any.
                        if (summary.free)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = free_idx;
                            wr_valid    = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_INSERTED;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign old_value   = old_reg;
    assign value_range = range_reg;
    // The count register changes only when a result is loaded, so it tracks
    // the entry count after the request shown in the result register.
    assign entry_count = count_reg;

endmodule

// ===== sim/key_value_table_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for key_value_table_core: a directed table of requests, then
// random traffic, each result checked against typed values or the behavioral table.
// Depends on kvt_pkg and the key_value_table_core RTL.

module key_value_table_core_tb;
    import kvt_pkg::*;

    localparam int CNT_W        = $clog2(KVT_ENTRIES + 1);
    localparam int POOL         = 24;    // more keys than slots, so the table can fill
    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_OFF     = 200;   // long output stall, counted in cycles
    localparam int HOLD_AT      = 300;   // results taken before the long stall
    localparam int SETTLE       = 40;    // wait after the last result before finishing

    typedef struct packed {
        logic [2:0]         status;
        logic               found;
        logic [VALUE_W-1:0] old_value;
        logic [RANGE_W-1:0] value_range;
        logic [CNT_W-1:0]   entry_count;
    } kvt_result_t;

    // One row of stimulus. Where typed is set, want holds the result written out
    // by hand; otherwise the result comes from the behavioral table.
    typedef struct packed {
        logic [1:0]         kind;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] new_value;
        logic               typed;
        kvt_result_t        want;
    } request_row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    logic [1:0]                kind      = KIND_GET;
    logic signed [KEY_W-1:0]   key       = '0;
    logic signed [VALUE_W-1:0] new_value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [2:0]                status;
    logic                      found;
    logic signed [VALUE_W-1:0] old_value;
    logic signed [RANGE_W-1:0] value_range;
    logic [CNT_W-1:0]          entry_count;

    // Behavioral copy of the store, advanced once per accepted item.
    bit                 tbl_valid [KVT_ENTRIES];
    logic [KEY_W-1:0]   tbl_key   [KVT_ENTRIES];
    logic [VALUE_W-1:0] tbl_value [KVT_ENTRIES];
    int                 tbl_count = 0;

    kvt_result_t        pending_results [$];
    logic [KEY_W-1:0]   key_pool [POOL];
    int                 errors = 0;

    key_value_table_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .key         (key),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found       (found),
        .old_value   (old_value),
        .value_range (value_range),
        .entry_count (entry_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Applies one request to the behavioral table and returns the result it gives.
    function automatic kvt_result_t table_request(logic [1:0] rq_kind,
                                                  logic [KEY_W-1:0] rq_key,
                                                  logic [VALUE_W-1:0] rq_value);
        kvt_result_t r;
        int          slot;
        int          i;
        bit          any;
        longint      lo;
        longint      hi;
        longint      x;
        r        = '0;
        r.status = ST_NOT_FOUND;
        if (rq_kind == KIND_RANGE)
        begin
            any = 1'b0;
            lo  = 0;
            hi  = 0;
            for (i = 0; i < KVT_ENTRIES; i++)
            begin
                if (tbl_valid[i])
                begin
                    x = $signed(tbl_value[i]);
                    if (!any || x < lo)
                        lo = x;
                    if (!any || x > hi)
                        hi = x;
                    any = 1'b1;
                end
            end
            r.status      = ST_RANGE;
            r.value_range = any ? RANGE_W'(hi - lo) : '1;
        end
        else
        begin
            slot = -1;
            for (i = 0; i < KVT_ENTRIES; i++)
                if (slot < 0 && tbl_valid[i] && tbl_key[i] == rq_key)
                    slot = i;
            if (slot >= 0)
            begin
                r.found     = 1'b1;
                r.old_value = tbl_value[slot];
                if (rq_kind == KIND_PUT)
                begin
                    tbl_value[slot] = rq_value;
                    r.status        = ST_UPDATED;
                end
                else if (rq_kind == KIND_GET)
                    r.status = ST_FOUND;
                else
                begin
                    tbl_valid[slot] = 1'b0;
                    tbl_count--;
                    r.status = ST_REMOVED;
                end
            end
            else if (rq_kind == KIND_PUT)
            begin
                // A new key takes the lowest free slot, if there is one.
                for (i = 0; i < KVT_ENTRIES; i++)
                    if (slot < 0 && !tbl_valid[i])
                        slot = i;
                if (slot >= 0)
                begin
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot]   = rq_key;
                    tbl_value[slot] = rq_value;
                    tbl_count++;
                    r.status = ST_INSERTED;
                end
                else
                    r.status = ST_FULL;
            end
        end
        r.entry_count = CNT_W'(tbl_count);
        return r;
    endfunction

    function automatic request_row_t make_row(logic [1:0] rq_kind, logic [KEY_W-1:0] rq_key,
                                              logic [VALUE_W-1:0] rq_value, logic typed,
                                              logic [2:0] st, logic fnd,
                                              logic [VALUE_W-1:0] old,
                                              logic [RANGE_W-1:0] rng,
                                              logic [CNT_W-1:0] cnt);
        request_row_t rw;
        rw.kind              = rq_kind;
        rw.key               = rq_key;
        rw.new_value         = rq_value;
        rw.typed             = typed;
        rw.want.status       = st;
        rw.want.found        = fnd;
        rw.want.old_value    = old;
        rw.want.value_range  = rng;
        rw.want.entry_count  = cnt;
        return rw;
    endfunction

    // Fill phases favor inserts, drain phases favor removals, so the table swings
    // between empty and full.
    function automatic logic [1:0] draw_kind(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < (filling ? 55 : 20))
            return KIND_PUT;
        else if (r < (filling ? 75 : 40))
            return KIND_GET;
        else if (r < 90)
            return KIND_DEL;
        else
            return KIND_RANGE;
    endfunction

    // Mostly keys from a small pool so that lookups and removals hit.
    function automatic logic [KEY_W-1:0] draw_key();
        if ($urandom_range(0, 15) == 0)
            return $urandom();
        return key_pool[$urandom_range(0, POOL - 1)];
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Offers one item, after a random gap unless no_idle is set, and waits for the
    // handshake. The expectation is queued at the edge where the item is taken.
    task automatic offer(input request_row_t rw, input bit no_idle);
        int          gap;
        kvt_result_t pred;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= rw.kind;
        key       <= rw.key;
        new_value <= rw.new_value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = table_request(rw.kind, rw.key, rw.new_value);
        pending_results.push_back(rw.typed ? rw.want : pred);
    endtask

    initial
    begin : stimulus
        request_row_t rows [$];
        int           i;
        int           n;
        for (i = 0; i < KVT_ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_value[i] = '0;
        end
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (i = 4; i < POOL; i++)
            key_pool[i] = $urandom();

        // Empty table: range gives -1, lookup and remove miss.
        rows.push_back(make_row(KIND_RANGE, 0, 0, 1, ST_RANGE, 0, 0, '1, 0));
        rows.push_back(make_row(KIND_GET, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0));
        rows.push_back(make_row(KIND_DEL, 32'hFFFF_FFFF, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0));
        // Extreme keys and values; the range spans the whole 32-bit signed scale.
        rows.push_back(make_row(KIND_PUT, 32'h8000_0000, 32'h8000_0000, 1,
                                ST_INSERTED, 0, 0, 0, 1));
        rows.push_back(make_row(KIND_PUT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                                ST_INSERTED, 0, 0, 0, 2));
        rows.push_back(make_row(KIND_RANGE, 0, 0, 1, ST_RANGE, 0, 0, 33'h0_FFFF_FFFF, 2));
        rows.push_back(make_row(KIND_GET, 32'h8000_0000, 0, 1,
                                ST_FOUND, 1, 32'h8000_0000, 0, 2));
        rows.push_back(make_row(KIND_PUT, 32'h7FFF_FFFF, 0, 1,
                                ST_UPDATED, 1, 32'h7FFF_FFFF, 0, 2));
        rows.push_back(make_row(KIND_DEL, 32'h8000_0000, 0, 1,
                                ST_REMOVED, 1, 32'h8000_0000, 0, 1));
        rows.push_back(make_row(KIND_DEL, 32'h8000_0000, 0, 1, ST_NOT_FOUND, 0, 0, 0, 1));
        // Fill every remaining slot, then a new key is refused as full.
        for (i = 0; i < KVT_ENTRIES - 1; i++)
            rows.push_back(make_row(KIND_PUT, 32'h1 << i, $urandom(), 0, 0, 0, 0, 0, 0));
        rows.push_back(make_row(KIND_PUT, 32'hFFFF_FFFF, 1, 1,
                                ST_FULL, 0, 0, 0, KVT_ENTRIES));
        rows.push_back(make_row(KIND_RANGE, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // The first item waits out the clearing pass through the stall.
        foreach (rows[i])
            offer(rows[i], 1'b0);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Halfway through, hold the input until the table has answered everything.
            if (n == RANDOM_ITEMS / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            offer(make_row(draw_kind(((n / 100) % 2) == 0), draw_key(), draw_value(),
                           0, 0, 0, 0, 0, 0),
                  ((n / 150) % 3) == 2);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls per item, one long hold-off so the block backs
    // up into its input, and stretches with no stalls at all.
    initial
    begin : results
        int          gap;
        int          taken;
        kvt_result_t want;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == HOLD_AT)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else
            begin
                gap = ((taken / 170) % 3 == 1) ? 0 : $urandom_range(0, 7);
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            taken++;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d", status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    errors++;
                end
                if (old_value !== want.old_value)
                begin
                    $error("old_value: expected %h, got %h", want.old_value, old_value);
                    errors++;
                end
                if (value_range !== want.value_range)
                begin
                    $error("value_range: expected %h, got %h", want.value_range, value_range);
                    errors++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
                    errors++;
                end
            end
        end
    end

    // A generous time limit: ends the run with TB_ERROR if the bench hangs.
    initial
    begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== key_value_table_core.f =====
sv/kvt_pkg.sv
sv/kvt_store.sv
sv/kvt_scan.sv
sv/key_value_table_core.sv
sim/key_value_table_core_tb.sv
